@@ src/kpar_pkg.sv @@
package kpar_pkg;

    localparam int unsigned COLS_W   = 4;
    localparam int unsigned CODE_W   = 4;
    localparam int unsigned KEY_W    = CODE_W + 1;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 8;

    typedef logic [COLS_W-1:0]     cols_t;
    typedef logic [CODE_W-1:0]     code_t;
    typedef logic [KEY_W-1:0]      key_t;
    typedef logic [COUNT_W-1:0]    count_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIRST_REPEAT  = 1'b0,
        REG_REPEAT_PERIOD = 1'b1
    } cfg_idx_t;

    // Top bit set marks "no key held".
    localparam key_t   NO_KEY            = key_t'(16);
    localparam count_t FIRST_REPEAT_RST  = count_t'(100);
    localparam count_t REPEAT_PERIOD_RST = count_t'(33);

    // Column index of a single pressed column; zero when several are pressed.
    function automatic logic [1:0] column_part(input cols_t pressed);
        logic [1:0] col;
        case (pressed)
            4'b0001: col = 2'd0;
            4'b0010: col = 2'd1;
            4'b0100: col = 2'd2;
            4'b1000: col = 2'd3;
            default: col = 2'd0;
        endcase
        return col;
    endfunction

endpackage

@@ src/kpar_if.sv @@
interface kpar_scan_if;
    logic            valid;
    logic            ready;
    kpar_pkg::cols_t row0_cols;
    kpar_pkg::cols_t row1_cols;
    kpar_pkg::cols_t row2_cols;
    kpar_pkg::cols_t row3_cols;

    modport source (output valid, output row0_cols, output row1_cols,
                    output row2_cols, output row3_cols, input ready);
    modport sink   (input valid, input row0_cols, input row1_cols,
                    input row2_cols, input row3_cols, output ready);
endinterface

interface kpar_key_if;
    logic            valid;
    logic            ready;
    kpar_pkg::code_t key_code;
    logic            is_repeat;

    modport source (output valid, output key_code, output is_repeat, input ready);
    modport sink   (input valid, input key_code, input is_repeat, output ready);
endinterface

interface kpar_cfg_if;
    logic                  valid;
    logic                  ready;
    kpar_pkg::cfg_idx_t    index;
    kpar_pkg::cfg_data_t   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/keypad_scan_auto_repeat.sv @@
// Channel  Role    Payload                            Moves
// scan     sink    row0_cols..row3_cols (4b each)     one scan tick per request
// key      source  key_code (4b), is_repeat (1b)      zero or one key per tick
// cfg      sink    index (1b), data (8b)              one register write per request
//
// A scan request is registered on acceptance and decoded in the next cycle; a
// resulting key enters the output register once it is free. One request
// is taken every cycle unless a stalled key holds it. Reset (rst_n, asynchronous)
// empties both stages, forgets the held key and loads the register defaults.
// While a key waits on a stalled output, the decode stage holds its request
// and scan ready drops only when that request would emit a key as well.
module keypad_scan_auto_repeat (
    input  logic       clk,
    input  logic       rst_n,
    kpar_scan_if.sink  scan,
    kpar_key_if.source key,
    kpar_cfg_if.sink   cfg
);

    // Input stage: one registered scan request.
    logic            in_valid_reg;
    kpar_pkg::cols_t rows_reg [4];

    // Output stage: one registered key.
    logic            out_valid_reg;
    kpar_pkg::code_t key_code_reg;
    logic            is_repeat_reg;

    // Scanner state and configuration.
    kpar_pkg::key_t   prev_key_reg;
    kpar_pkg::key_t   prev_key_next;
    kpar_pkg::count_t hold_reg;
    kpar_pkg::count_t hold_next;
    kpar_pkg::count_t first_repeat_reg;
    kpar_pkg::count_t repeat_period_reg;

    // Decode results for the request in the input stage.
    logic             found;
    logic [1:0]       win_row;
    kpar_pkg::cols_t  win_pressed;
    kpar_pkg::cols_t  pressed;
    kpar_pkg::key_t   cur_key;
    kpar_pkg::count_t hold_inc;
    logic             emit;
    logic             emit_repeat;

    logic             out_free;
    logic             advance;
    logic             scan_accept;

    // Find the winning row: the highest row index with any column pulled low.
    always_comb
    begin
        found       = 1'b0;
        win_row     = 2'd0;
        win_pressed = '0;
        pressed     = '0;
        for (int r = 0; r < 4; r++)
        begin
            pressed = ~rows_reg[r];
            if (pressed != '0)
            begin
                found       = 1'b1;
                win_row     = 2'(r);
                win_pressed = pressed;
            end
        end
    end

    assign cur_key  = {1'b0, win_row, kpar_pkg::column_part(win_pressed)};
    assign hold_inc = hold_reg + kpar_pkg::count_t'(1);

    // Press, repeat or silence, and the state that follows.
    always_comb
    begin
        prev_key_next = prev_key_reg;
        hold_next     = hold_reg;
        emit          = 1'b0;
        emit_repeat   = 1'b0;
        if (!found)
        begin
            // Release: forget the key, keep the counter for the next press to clear.
            prev_key_next = kpar_pkg::NO_KEY;
        end
        else if (cur_key != prev_key_reg)
        begin
            prev_key_next = cur_key;
            hold_next     = '0;
            emit          = 1'b1;
        end
        else
        begin
            hold_next = hold_inc;
            if (hold_inc == first_repeat_reg)
            begin
                emit        = 1'b1;
                emit_repeat = 1'b1;
                // Drop by the period, clamping at zero.
                if (repeat_period_reg > hold_inc)
                begin
                    hold_next = '0;
                end
                else
                begin
                    hold_next = hold_inc - repeat_period_reg;
                end
            end
        end
    end

    // The output register can take a key when empty or being drained.
    assign out_free    = !out_valid_reg || key.ready;
    // A silent tick never waits on the output side.
    assign advance     = in_valid_reg && (out_free || !emit);
    assign scan.ready  = !in_valid_reg || advance;
    assign scan_accept = scan.valid && scan.ready;

    assign key.valid     = out_valid_reg;
    assign key.key_code  = key_code_reg;
    assign key.is_repeat = is_repeat_reg;

    assign cfg.ready = 1'b1;

    // Control state, scanner state and registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            prev_key_reg      <= kpar_pkg::NO_KEY;
            hold_reg          <= '0;
            first_repeat_reg  <= kpar_pkg::FIRST_REPEAT_RST;
            repeat_period_reg <= kpar_pkg::REPEAT_PERIOD_RST;
        end
        else
        begin
            if (scan_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (key.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                prev_key_reg <= prev_key_next;
                hold_reg     <= hold_next;
            end

            if (cfg.valid)
            begin
                unique case (cfg.index)
                    kpar_pkg::REG_FIRST_REPEAT:  first_repeat_reg  <= cfg.data;
                    kpar_pkg::REG_REPEAT_PERIOD: repeat_period_reg <= cfg.data;
                    default: ;
                endcase
            end
        end
    end

    // Payload: capture on acceptance, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (scan_accept)
        begin
            rows_reg[0] <= scan.row0_cols;
            rows_reg[1] <= scan.row1_cols;
            rows_reg[2] <= scan.row2_cols;
            rows_reg[3] <= scan.row3_cols;
        end
        if (advance && emit)
        begin
            key_code_reg  <= cur_key[kpar_pkg::CODE_W-1:0];
            is_repeat_reg <= emit_repeat;
        end
    end

endmodule

@@ verif/tb.sv @@
module tb;

    // One expected key as it should leave the key channel.
    typedef struct packed {
        kpar_pkg::code_t code;
        logic            rep;
    } key_result_t;

    // Scoreboard: tracks the held key and the hold counter, and queues the
    // keys each accepted scan request should produce.
    class key_scoreboard;
        kpar_pkg::count_t first_ticks;
        kpar_pkg::count_t period;
        kpar_pkg::key_t   last_key;
        kpar_pkg::count_t hold;
        key_result_t      expected[$];
        int               errors;

        function new();
            first_ticks = kpar_pkg::FIRST_REPEAT_RST;
            period      = kpar_pkg::REPEAT_PERIOD_RST;
            last_key    = kpar_pkg::NO_KEY;
            hold        = '0;
            errors      = 0;
        endfunction

        function void set_reg(kpar_pkg::cfg_idx_t idx, kpar_pkg::cfg_data_t value);
            if (idx == kpar_pkg::REG_FIRST_REPEAT)
                first_ticks = kpar_pkg::count_t'(value);
            else
                period = kpar_pkg::count_t'(value);
        endfunction

        function logic [1:0] single_column(kpar_pkg::cols_t pressed);
            logic [1:0] col;
            col = 2'd0;
            for (int c = 0; c < 4; c++)
                if (pressed == kpar_pkg::cols_t'(1 << c))
                    col = c[1:0];
            return col;
        endfunction

        function void note_scan(kpar_pkg::cols_t r0, kpar_pkg::cols_t r1,
                                kpar_pkg::cols_t r2, kpar_pkg::cols_t r3);
            kpar_pkg::cols_t rows[4];
            kpar_pkg::cols_t pressed;
            kpar_pkg::cols_t p;
            logic [1:0]      row;
            logic            found;
            kpar_pkg::key_t  code;
            key_result_t     res;
            rows    = '{r0, r1, r2, r3};
            found   = 1'b0;
            row     = 2'd0;
            pressed = '0;
            for (int r = 0; r < 4; r++)
            begin
                p = ~rows[r];
                if (p != '0)
                begin
                    found   = 1'b1;
                    row     = r[1:0];
                    pressed = p;
                end
            end
            if (!found)
            begin
                last_key = kpar_pkg::NO_KEY;
                return;
            end
            code = {1'b0, row, single_column(pressed)};
            if (code != last_key)
            begin
                last_key = code;
                hold     = '0;
                res.code = code[kpar_pkg::CODE_W-1:0];
                res.rep  = 1'b0;
                expected.push_back(res);
                return;
            end
            hold = hold + kpar_pkg::count_t'(1);
            if (hold == first_ticks)
            begin
                if (period > hold)
                    hold = '0;
                else
                    hold = hold - period;
                res.code = code[kpar_pkg::CODE_W-1:0];
                res.rep  = 1'b1;
                expected.push_back(res);
            end
        endfunction

        task report(string msg);
            $display("%0t mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_key(kpar_pkg::code_t code, logic rep);
            key_result_t want;
            if (expected.size() == 0)
            begin
                report($sformatf("key %0d repeat %0b with none expected", code, rep));
                return;
            end
            want = expected.pop_front();
            if (code !== want.code)
                report($sformatf("key_code %0d, expected %0d", code, want.code));
            if (rep !== want.rep)
                report($sformatf("is_repeat %0b, expected %0b", rep, want.rep));
        endtask
    endclass

    logic clk;
    logic rst_n;
    bit   quiet;

    kpar_scan_if scan();
    kpar_key_if  key();
    kpar_cfg_if  cfg();

    key_scoreboard sb = new();

    keypad_scan_auto_repeat dut (
        .clk   (clk),
        .rst_n (rst_n),
        .scan  (scan),
        .key   (key),
        .cfg   (cfg)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs on a handshake.
    initial
    begin
        #5000000;
        $display("keypad_scan_auto_repeat test failed");
        $finish;
    end

    // Key channel back-pressure: runs of ready mixed with stall bursts, each
    // burst followed by a ready run; hold ready high once the run goes quiet.
    initial
    begin
        int run;
        bit stalled;
        run     = 0;
        stalled = 1'b0;
        key.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (run == 0)
            begin
                if (stalled || $urandom_range(0, 2) == 0)
                begin
                    stalled = 1'b0;
                    run     = $urandom_range(1, 16);
                end
                else
                begin
                    stalled = 1'b1;
                    run     = $urandom_range(1, 9);
                end
            end
            run--;
            key.ready <= quiet ? 1'b1 : !stalled;
        end
    end

    // Sample the key channel on the edge; values seen here are pre-edge.
    always @(posedge clk)
    begin
        if (rst_n && key.valid && key.ready)
            sb.check_key(key.key_code, key.is_repeat);
    end

    // Drop scan valid for a burst of idle cycles.
    task automatic idle_scan(int n);
        scan.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Offer one scan request and hold it until the block takes it; note it
    // in the scoreboard on acceptance.
    task automatic send_tick(kpar_pkg::cols_t r0, kpar_pkg::cols_t r1,
                             kpar_pkg::cols_t r2, kpar_pkg::cols_t r3);
        if (!quiet && $urandom_range(0, 3) == 0)
            idle_scan($urandom_range(1, 9));
        scan.valid     <= 1'b1;
        scan.row0_cols <= r0;
        scan.row1_cols <= r1;
        scan.row2_cols <= r2;
        scan.row3_cols <= r3;
        do @(posedge clk); while (!scan.ready);
        sb.note_scan(r0, r1, r2, r3);
    endtask

    // Drive one tick with row 'row' showing 'pat'. Rows below it carry noise,
    // since the highest pressed row wins; rows above stay released.
    task automatic press_tick(int row, kpar_pkg::cols_t pat);
        kpar_pkg::cols_t rows[4];
        for (int r = 0; r < 4; r++)
        begin
            if (r < row)
                rows[r] = kpar_pkg::cols_t'($urandom);
            else if (r == row)
                rows[r] = pat;
            else
                rows[r] = 4'hF;
        end
        send_tick(rows[0], rows[1], rows[2], rows[3]);
    endtask

    task automatic hold_key(int row, kpar_pkg::cols_t pat, int n);
        repeat (n) press_tick(row, pat);
    endtask

    task automatic release_tick();
        send_tick(4'hF, 4'hF, 4'hF, 4'hF);
    endtask

    // Mostly a single column; now and then several columns at once.
    function automatic kpar_pkg::cols_t random_pattern();
        if ($urandom_range(0, 3) != 0)
            return ~kpar_pkg::cols_t'(1 << $urandom_range(0, 3));
        return kpar_pkg::cols_t'($urandom_range(0, 14));
    endfunction

    // Stop offering requests and let the pipeline drain: wait for every key
    // owed, then wait out a request that produces nothing.
    task automatic settle();
        scan.valid <= 1'b0;
        while (sb.expected.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write both registers back to back, then drop the write request.
    task automatic program_regs(kpar_pkg::cfg_data_t first, kpar_pkg::cfg_data_t period);
        cfg.valid <= 1'b1;
        cfg.index <= kpar_pkg::REG_FIRST_REPEAT;
        cfg.data  <= first;
        do @(posedge clk); while (!cfg.ready);
        sb.set_reg(kpar_pkg::REG_FIRST_REPEAT, first);
        cfg.index <= kpar_pkg::REG_REPEAT_PERIOD;
        cfg.data  <= period;
        do @(posedge clk); while (!cfg.ready);
        sb.set_reg(kpar_pkg::REG_REPEAT_PERIOD, period);
        cfg.valid <= 1'b0;
    endtask

    task automatic new_phase(kpar_pkg::cfg_data_t first, kpar_pkg::cfg_data_t period);
        settle();
        program_regs(first, period);
    endtask

    // Random traffic: mostly held keys of random length, some long enough to
    // reach and pass the first repeat, plus releases and pure noise. Trim the
    // last hold so the phase sends exactly n requests.
    task automatic random_phase(int n);
        int sent;
        int pick;
        int run;
        sent = 0;
        while (sent < n)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 14)
            begin
                if (pick < 3)
                    run = int'(sb.first_ticks) + $urandom_range(0, 2 * int'(sb.period) + 2);
                else
                    run = $urandom_range(1, 6);
                if (run > 300)
                    run = 300;
                if (run > n - sent)
                    run = n - sent;
                hold_key($urandom_range(0, 3), random_pattern(), run);
                sent += run;
            end
            else if (pick < 17)
            begin
                release_tick();
                sent++;
            end
            else
            begin
                send_tick(kpar_pkg::cols_t'($urandom), kpar_pkg::cols_t'($urandom),
                          kpar_pkg::cols_t'($urandom), kpar_pkg::cols_t'($urandom));
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        scan.valid     <= 1'b0;
        scan.row0_cols <= 4'hF;
        scan.row1_cols <= 4'hF;
        scan.row2_cols <= 4'hF;
        scan.row3_cols <= 4'hF;
        cfg.valid      <= 1'b0;
        cfg.index      <= kpar_pkg::REG_FIRST_REPEAT;
        cfg.data       <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Decode at the reset defaults: silent tick, corner keys, several
        // columns in one row, and the highest pressed row taking priority.
        release_tick();
        send_tick(4'hE, 4'hF, 4'hF, 4'hF);
        send_tick(4'hF, 4'hF, 4'hF, 4'h7);
        send_tick(4'h0, 4'hF, 4'hF, 4'hF);
        send_tick(4'hF, 4'hF, 4'hF, 4'h0);
        send_tick(4'hF, 4'hE, 4'hB, 4'hF);
        send_tick(4'hF, 4'hF, 4'h5, 4'hF);
        release_tick();
        send_tick(4'hF, 4'hB, 4'hF, 4'hF);

        // Period larger than the count: repeat clears the counter to zero.
        new_phase(8'd2, 8'd5);
        hold_key(1, 4'hD, 6);

        // Period of one with a short first repeat: a repeat on every tick once the first repeat is reached.
        new_phase(8'd3, 8'd1);
        hold_key(0, 4'h7, 7);
        release_tick();

        // Counter overflow: build up a long hold, lower the first-repeat
        // count beneath it, and keep the same key held across the write.
        new_phase(8'd200, 8'd1);
        hold_key(2, 4'hB, 150);
        new_phase(8'd20, 8'd1);
        hold_key(2, 4'hB, 130);
        release_tick();

        // Registers at zero: first repeat only on the wrap, and a zero period
        // leaves the counter where it is.
        new_phase(8'd0, 8'd0);
        hold_key(3, 4'hE, 260);
        new_phase(8'd4, 8'd0);
        hold_key(1, 4'h3, 12);

        new_phase(8'd1, 8'd1);
        random_phase(80);
        new_phase(8'd2, 8'd255);
        random_phase(100);
        new_phase(8'd3, 8'd1);
        random_phase(80);
        new_phase(8'd5, 8'd2);
        random_phase(80);
        new_phase(kpar_pkg::cfg_data_t'($urandom_range(1, 12)),
                  kpar_pkg::cfg_data_t'($urandom_range(1, 12)));
        random_phase(80);
        new_phase(kpar_pkg::cfg_data_t'($urandom_range(1, 12)),
                  kpar_pkg::cfg_data_t'($urandom_range(1, 12)));
        random_phase(80);

        // Last stretch runs flat out on both sides.
        new_phase(8'd4, 8'd2);
        quiet = 1'b1;
        random_phase(150);

        scan.valid <= 1'b0;
        while (sb.expected.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.expected.size() == 0)
            $display("keypad_scan_auto_repeat test passed");
        else
            $display("keypad_scan_auto_repeat test failed");
        $finish;
    end

endmodule

@@ filelist.f @@
src/kpar_pkg.sv
src/kpar_if.sv
src/keypad_scan_auto_repeat.sv
verif/tb.sv
